/* src/pixel_color_math_compositor_macros.svh */
// ----------------------------------------------------------------------------
// Pixel color math compositor assertion macros
// Clocked assertion helpers shared by the compositor modules.
// ----------------------------------------------------------------------------
`ifndef PIXEL_COLOR_MATH_COMPOSITOR_MACROS_SVH
`define PIXEL_COLOR_MATH_COMPOSITOR_MACROS_SVH

`ifndef SYNTHESIS
`define PCMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PCMC_NEVER(lbl, cond, msg) \
  `PCMC_ASSERT(lbl, !(cond), msg)
`else
`define PCMC_ASSERT(lbl, prop, msg)
`define PCMC_NEVER(lbl, cond, msg)
`endif

`endif

/* src/pcmc_pkg.sv */
// ----------------------------------------------------------------------------
// Pixel color math compositor package
// Shared types, register indexes and per-channel arithmetic.
// ----------------------------------------------------------------------------
package pcmc_pkg;

  localparam int COLOR_W = 15;
  localparam int CHAN_W  = 5;
  localparam int LAYER_W = 3;
  localparam int BRI_W   = 4;
  localparam int MASK_W  = 7;
  localparam int PROD_W  = CHAN_W + BRI_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [LAYER_W-1:0] LAYER_NOBLEND  = 3'd5;
  localparam logic [LAYER_W-1:0] LAYER_BACKDROP = 3'd6;

  // 1093 / 2^15 is just above 1/30; exact floor for numerators up to 945
  localparam logic [10:0] RECIP_30    = 11'd1093;
  localparam int          RECIP_SHIFT = 15;

  typedef enum logic [2:0] {
    REG_SUBTRACT_MODE    = 3'd0,
    REG_HALVE_ENABLE     = 3'd1,
    REG_SUB_SCREEN_MODE  = 3'd2,
    REG_BLEND_LAYER_MASK = 3'd3,
    REG_FIXED_COLOR      = 3'd4,
    REG_BRIGHTNESS       = 3'd5,
    REG_HIRES_MODE       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic               subtract_mode;
    logic               halve_enable;
    logic               sub_screen_mode;
    logic [MASK_W-1:0]  blend_layer_mask;
    logic [COLOR_W-1:0] fixed_color;
    logic [BRI_W-1:0]   brightness;
    logic               hires_mode;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] a_color;
    logic [LAYER_W-1:0] a_layer;
    logic [COLOR_W-1:0] b_color;
    logic [LAYER_W-1:0] b_layer;
    logic               window_main;
    logic               window_sub;
    logic               final_of_pair;
  } job_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel;
    logic               final_of_pair;
  } res_t;

  function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] x,
                                                   input logic [CHAN_W-1:0] y,
                                                   input logic sub,
                                                   input logic halve);
    logic [CHAN_W:0]   s;
    logic [CHAN_W-1:0] d;
    logic [CHAN_W-1:0] r;
    s = {1'b0, x} + {1'b0, y};
    d = (x > y) ? (x - y) : '0;
    if (sub) begin
      r = halve ? (d >> 1) : d;
    end else if (halve) begin
      r = s[CHAN_W:1];
    end else begin
      r = s[CHAN_W] ? '1 : s[CHAN_W-1:0];
    end
    return r;
  endfunction

  // round(p / 15) computed as (2p + 15) / 30
  function automatic logic [CHAN_W-1:0] light_chan(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] x;
    logic [20:0]     prod;
    x    = {p, 1'b0} + (PROD_W+1)'(15);
    prod = 21'(x) * 21'(RECIP_30);
    return prod[RECIP_SHIFT +: CHAN_W];
  endfunction

endpackage

/* src/pcmc_front.sv */
// ----------------------------------------------------------------------------
// Pixel color math compositor front end
// Accepts input pixels and splits each into one or two composite jobs.
// ----------------------------------------------------------------------------
`include "pixel_color_math_compositor_macros.svh"

module pcmc_front
  import pcmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               push,
  output logic               full,
  input  logic [COLOR_W-1:0] main_bgr,
  input  logic [LAYER_W-1:0] main_layer,
  input  logic [COLOR_W-1:0] sub_bgr,
  input  logic [LAYER_W-1:0] sub_layer,
  input  logic               window_main,
  input  logic               window_sub,
  input  logic               q_full,
  output logic               q_push,
  output job_t               q_data
);

  logic pend_valid;
  logic pend_valid_next;
  job_t pend_job;
  logic accept;
  job_t job_normal;
  job_t job_swap;

  assign full   = pend_valid | q_full;
  assign accept = push & ~full;

  always_comb begin
    job_normal = '{a_color: main_bgr, a_layer: main_layer,
                   b_color: sub_bgr, b_layer: sub_layer,
                   window_main: window_main, window_sub: window_sub,
                   final_of_pair: 1'b1};
    job_swap   = '{a_color: sub_bgr, a_layer: sub_layer,
                   b_color: main_bgr, b_layer: main_layer,
                   window_main: window_main, window_sub: window_sub,
                   final_of_pair: 1'b0};
  end

  assign q_push = pend_valid ? ~q_full : accept;
  assign q_data = pend_valid ? pend_job : (cfg.hires_mode ? job_swap : job_normal);

  always_comb begin
    pend_valid_next = pend_valid;
    if (pend_valid && !q_full) begin
      pend_valid_next = 1'b0;
    end else if (accept && cfg.hires_mode) begin
      pend_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_job <= job_normal;
    end
  end

  `PCMC_ASSERT(a_pend_from_hires, $rose(pend_valid) |-> $past(accept && cfg.hires_mode),
               "second job without hires transfer")

endmodule

/* src/pcmc_job_q.sv */
// ----------------------------------------------------------------------------
// Pixel color math compositor job queue
// Short register queue decoupling the front end from the datapath.
// ----------------------------------------------------------------------------
`include "pixel_color_math_compositor_macros.svh"

module pcmc_job_q
  import pcmc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `PCMC_NEVER(a_no_push_full, push && full, "job pushed into full queue")
  `PCMC_NEVER(a_no_pop_empty, pop && empty, "job popped from empty queue")

endmodule

/* src/pcmc_back.sv */
// ----------------------------------------------------------------------------
// Pixel color math compositor back end
// Three-stage composite and brightness datapath with a result queue.
// ----------------------------------------------------------------------------
`include "pixel_color_math_compositor_macros.svh"

module pcmc_back
  import pcmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  job_t               q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [COLOR_W-1:0] pixel_out,
  output logic               final_of_pair
);

  logic                 adv;
  logic                 s1_valid;
  logic [COLOR_W-1:0]   s1_color;
  logic                 s1_final;
  logic                 s2_valid;
  logic [PROD_W-1:0]    s2_prod [3];
  logic                 s2_final;
  logic                 s3_valid;
  logic [COLOR_W-1:0]   s3_pix;
  logic                 s3_final;

  logic [COLOR_W-1:0]   b_color;
  logic [LAYER_W-1:0]   b_layer;
  logic [COLOR_W-1:0]   a_color;
  logic [MASK_W:0]      mask_ext;
  logic                 do_math;
  logic                 halve;
  logic [COLOR_W-1:0]   blended;
  logic [COLOR_W-1:0]   composed;

  res_t                 res_mem [QDEPTH];
  logic [QPTR_W-1:0]    res_wr;
  logic [QPTR_W-1:0]    res_rd;
  logic [QCNT_W-1:0]    res_count;
  logic                 res_full;
  logic                 res_push;
  logic                 res_pop;

  assign res_full = (res_count == QCNT_W'(QDEPTH));
  assign empty    = (res_count == '0);
  assign adv      = ~(s3_valid & res_full);
  assign q_pop    = adv & ~q_empty;
  assign res_push = s3_valid & ~res_full;
  assign res_pop  = pop & ~empty;

  // composite
  always_comb begin
    b_color  = cfg.sub_screen_mode ? q_data.b_color : cfg.fixed_color;
    b_layer  = cfg.sub_screen_mode ? q_data.b_layer : LAYER_BACKDROP;
    a_color  = q_data.window_main ? q_data.a_color : '0;
    mask_ext = {1'b0, cfg.blend_layer_mask};
    do_math  = (q_data.a_layer != LAYER_NOBLEND) && mask_ext[q_data.a_layer]
               && q_data.window_sub;
    halve    = cfg.halve_enable && q_data.window_main
               && (!cfg.sub_screen_mode || (b_layer != LAYER_BACKDROP));
    for (int i = 0; i < 3; i++) begin
      blended[i*CHAN_W +: CHAN_W] = blend_chan(a_color[i*CHAN_W +: CHAN_W],
                                               b_color[i*CHAN_W +: CHAN_W],
                                               cfg.subtract_mode, halve);
    end
    if (!q_data.window_main && !q_data.window_sub) begin
      composed = '0;
    end else if (do_math) begin
      composed = blended;
    end else begin
      composed = a_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= ~q_empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_color <= composed;
      s1_final <= q_data.final_of_pair;
      for (int i = 0; i < 3; i++) begin
        s2_prod[i] <= PROD_W'(s1_color[i*CHAN_W +: CHAN_W]) * PROD_W'(cfg.brightness);
      end
      s2_final <= s1_final;
      // low channel moves to the top field and the top channel to the low field
      s3_pix   <= {light_chan(s2_prod[0]), light_chan(s2_prod[1]),
                   light_chan(s2_prod[2])};
      s3_final <= s2_final;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= '0;
      res_rd    <= '0;
      res_count <= '0;
    end else begin
      if (res_push) begin
        res_wr <= res_wr + 1'b1;
      end
      if (res_pop) begin
        res_rd <= res_rd + 1'b1;
      end
      if (res_push && !res_pop) begin
        res_count <= res_count + 1'b1;
      end else if (res_pop && !res_push) begin
        res_count <= res_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wr] <= '{pixel: s3_pix, final_of_pair: s3_final};
    end
  end

  assign pixel_out     = res_mem[res_rd].pixel;
  assign final_of_pair = res_mem[res_rd].final_of_pair;

  `PCMC_ASSERT(a_stall_holds, s3_valid && res_full |=> s3_valid && $stable(s3_pix), "stalled result lost")
  `PCMC_NEVER(a_res_count, res_count > QCNT_W'(QDEPTH), "result queue overflow")

endmodule

/* src/pixel_color_math_compositor.sv */
// ----------------------------------------------------------------------------
// Pixel color math compositor
// Blends main and sub screen colors, applies brightness, emits pixels.
// ----------------------------------------------------------------------------
// Input channel: present a pixel with push; it transfers when full is low.
// Result channel: while empty is low the oldest pixel is on pixel_out and
// final_of_pair; pop transfers it. Configuration: cfg_ready is always high,
// a cfg_valid cycle writes cfg_data to register cfg_index (unused indexes
// are dropped); write only while no pixel is in flight.
// Path: a result passes the job queue, the datapath stages and the result
// queue; in hires mode the second result follows the first. Throughput: one
// input per cycle in normal mode while full is low; in hires mode the single
// push port of the job queue (one job per cycle) takes both jobs per input.
// The datapath is three registered stages: composite, brightness product,
// divide by 15 with rounding.
// Reset clears all queues and sets brightness to 15, other registers to 0.
// When the receiver stalls, the 4-entry result queue fills, the datapath
// holds, then the 4-entry job queue fills and full rises.
// ----------------------------------------------------------------------------
module pixel_color_math_compositor
  import pcmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [COLOR_W-1:0] main_bgr,
  input  logic [LAYER_W-1:0] main_layer,
  input  logic [COLOR_W-1:0] sub_bgr,
  input  logic [LAYER_W-1:0] sub_layer,
  input  logic               window_main,
  input  logic               window_sub,
  output logic               empty,
  input  logic               pop,
  output logic [COLOR_W-1:0] pixel_out,
  output logic               final_of_pair,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [COLOR_W-1:0] cfg_data
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  job_t q_wdata;
  logic q_pop;
  job_t q_rdata;
  logic q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{subtract_mode: 1'b0, halve_enable: 1'b0, sub_screen_mode: 1'b0,
               blend_layer_mask: '0, fixed_color: '0, brightness: '1,
               hires_mode: 1'b0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SUBTRACT_MODE:    cfg.subtract_mode    <= cfg_data[0];
        REG_HALVE_ENABLE:     cfg.halve_enable     <= cfg_data[0];
        REG_SUB_SCREEN_MODE:  cfg.sub_screen_mode  <= cfg_data[0];
        REG_BLEND_LAYER_MASK: cfg.blend_layer_mask <= cfg_data[MASK_W-1:0];
        REG_FIXED_COLOR:      cfg.fixed_color      <= cfg_data;
        REG_BRIGHTNESS:       cfg.brightness       <= cfg_data[BRI_W-1:0];
        REG_HIRES_MODE:       cfg.hires_mode       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pcmc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .main_bgr    (main_bgr),
    .main_layer  (main_layer),
    .sub_bgr     (sub_bgr),
    .sub_layer   (sub_layer),
    .window_main (window_main),
    .window_sub  (window_sub),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  pcmc_job_q u_job_q (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  pcmc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .pixel_out     (pixel_out),
    .final_of_pair (final_of_pair)
  );

endmodule
